// ----- hw/rtl/vwh_pkg.sv -----
// Package for the vertex weld hash table: sizes, payload structs, state enums, quantizer.
// No dependencies.
package vwh_pkg;

    localparam int TableEntries = 4096;
    localparam int SlotBits     = 12;
    localparam int CoordBits    = 48;
    localparam int IndexBits    = 12;
    localparam int CountBits    = 13;
    localparam int ShiftBits    = 6;
    localparam int QueueDepth   = 2;

    localparam logic [31:0] HashMulX = 32'd73856093;
    localparam logic [31:0] HashMulY = 32'd19349663;
    localparam logic [31:0] HashMulZ = 32'd83492791;

    localparam logic [ShiftBits-1:0] QuantShiftReset = 6'd20;

    typedef enum logic {
        ACT_WELD  = 1'b0,
        ACT_CLEAR = 1'b1
    } t_action;

    typedef struct packed {
        logic                        action;
        logic signed [CoordBits-1:0] coord_x;
        logic signed [CoordBits-1:0] coord_y;
        logic signed [CoordBits-1:0] coord_z;
    } t_in_item;

    typedef struct packed {
        logic [IndexBits-1:0] vertex_index;
        logic                 is_new;
        logic                 table_full;
    } t_out_item;

    // Classified job handed from front to back.
    typedef struct packed {
        logic                 clear;
        logic [CoordBits-1:0] key_x;
        logic [CoordBits-1:0] key_y;
        logic [CoordBits-1:0] key_z;
        logic [SlotBits-1:0]  slot;
    } t_job;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_QUANT,
        FS_MUL,
        FS_HASH,
        FS_PUSH
    } t_front_state;

    // BS_INIT sweeps the used bits after reset, BS_CLEAR does the same for a clear job
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_READ,
        BS_CHECK,
        BS_CLEAR,
        BS_INIT
    } t_back_state;

    // Quantize: round magnitude half away from zero, then restore sign.
    function automatic logic [CoordBits-1:0] quantize(
        input logic [CoordBits-1:0] v,
        input logic [ShiftBits-1:0] s
    );
        logic                 neg;
        logic [CoordBits:0]   mag;
        logic [CoordBits:0]   rnd;
        logic [CoordBits:0]   key;
        neg = v[CoordBits-1];
        mag = neg ? ({1'b0, ~v} + {{CoordBits{1'b0}}, 1'b1}) : {1'b0, v};
        if (s == '0) begin
            key = mag;
        end else begin
            rnd = ({(CoordBits+1){1'b0}} | ((CoordBits+1)'(1) << (s - 6'd1)));
            key = (mag + rnd) >> s;
        end
        if (neg) begin
            key = ~key + (CoordBits+1)'(1);
        end
        return key[CoordBits-1:0];
    endfunction

endpackage

// ----- hw/rtl/vwh_front.sv -----
// Front end: takes a transfer, quantizes, hashes the key triple, queues the job; a clear goes straight to the queue.
// Depends on vwh_pkg.
module vwh_front import vwh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  t_in_item             i_item,
    input  logic [ShiftBits-1:0] i_quant_shift,
    input  logic                 i_q_ready,
    output logic                 o_busy,
    output logic                 o_q_valid,
    output t_job                 o_q_job
);

    t_front_state r_state, n_state;
    t_in_item     r_item;
    logic [CoordBits-1:0] r_kx, r_ky, r_kz;
    logic [SlotBits-1:0]  r_px, r_py, r_pz;
    logic [SlotBits-1:0]  r_slot;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE:  if (i_take) n_state = (i_item.action == ACT_CLEAR) ? FS_PUSH : FS_QUANT;
            FS_QUANT: n_state = FS_MUL;
            FS_MUL:   n_state = FS_HASH;
            FS_HASH:  n_state = FS_PUSH;
            FS_PUSH:  if (i_q_ready) n_state = FS_IDLE;
            default:  n_state = FS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_busy          = (r_state != FS_IDLE);
        o_q_valid       = (r_state == FS_PUSH);
        o_q_job.clear   = r_item.action;
        o_q_job.key_x   = r_kx;
        o_q_job.key_y   = r_ky;
        o_q_job.key_z   = r_kz;
        o_q_job.slot    = r_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath; only low slot bits of the hash matter, so products are narrow.
    always_ff @(posedge i_clk) begin
        if (r_state == FS_IDLE && i_take) begin
            r_item <= i_item;
        end
        if (r_state == FS_QUANT) begin
            r_kx <= quantize(r_item.coord_x, i_quant_shift);
            r_ky <= quantize(r_item.coord_y, i_quant_shift);
            r_kz <= quantize(r_item.coord_z, i_quant_shift);
        end
        if (r_state == FS_MUL) begin
            r_px <= SlotBits'(r_kx[SlotBits-1:0] * HashMulX[SlotBits-1:0]);
            r_py <= SlotBits'(r_ky[SlotBits-1:0] * HashMulY[SlotBits-1:0]);
            r_pz <= SlotBits'(r_kz[SlotBits-1:0] * HashMulZ[SlotBits-1:0]);
        end
        if (r_state == FS_HASH) begin
            r_slot <= r_px ^ r_py ^ r_pz;
        end
    end

endmodule

// ----- hw/rtl/vwh_queue.sv -----
// Short job queue between the front and back ends.
// Depends on vwh_pkg.
module vwh_queue import vwh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PtrBits = $clog2(QueueDepth);

    t_job               r_mem [QueueDepth];
    logic [PtrBits-1:0] r_wr, r_rd;
    logic [PtrBits:0]   r_cnt;
    logic               w_push, w_pop;

    assign o_ready = (r_cnt != (PtrBits+1)'(QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + PtrBits'(1);
            if (w_pop)  r_rd <= r_rd + PtrBits'(1);
            r_cnt <= r_cnt + (PtrBits+1)'(w_push) - (PtrBits+1)'(w_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PtrBits+1)'(QueueDepth))
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("empty queue with unequal pointers");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + (PtrBits+1)'(1)))
        else $error("queue count missed a push");

endmodule

// ----- hw/rtl/vwh_back.sv -----
// Back end: linear probe over the slot memory, insert or find, clear and reset sweeps.
// Depends on vwh_pkg.
module vwh_back import vwh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_idle,
    output logic      o_res_valid,
    output t_out_item o_res
);

    localparam int KeyBits = 3 * CoordBits;

    // Slot memory: keys, vertex index and used bit, one read and one write a cycle
    logic [KeyBits-1:0]   r_key_mem [TableEntries];
    logic [IndexBits-1:0] r_vtx_mem [TableEntries];
    logic                 r_used_mem [TableEntries];

    t_back_state          r_state, n_state;
    t_job                 r_job;
    logic [SlotBits-1:0]  r_slot;
    logic [SlotBits:0]    r_probes;
    logic [CountBits-1:0] r_next;
    logic [KeyBits-1:0]   r_rd_key;
    logic [IndexBits-1:0] r_rd_vtx;
    logic                 r_rd_used;
    t_out_item            r_res;
    logic                 r_res_valid;

    logic w_hit, w_free, w_full, w_last, w_wr, w_sweep, w_sweep_end;
    logic [KeyBits-1:0] w_key;

    assign w_key       = {r_job.key_x, r_job.key_y, r_job.key_z};
    assign w_hit       = r_rd_used && (r_rd_key == w_key);
    assign w_free      = !r_rd_used;
    assign w_full      = (r_next >= CountBits'(TableEntries));
    assign w_last      = (r_probes == (SlotBits+1)'(TableEntries - 1));
    assign w_wr        = (r_state == BS_CHECK) && w_free && !w_full;
    assign w_sweep     = (r_state == BS_INIT) || (r_state == BS_CLEAR);
    assign w_sweep_end = w_sweep && (r_slot == SlotBits'(TableEntries - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE:  if (i_valid) n_state = i_job.clear ? BS_CLEAR : BS_READ;
            BS_READ:  n_state = BS_CHECK;
            BS_CHECK: if (w_free || w_hit || w_last) n_state = BS_IDLE;
                      else n_state = BS_READ;
            BS_CLEAR: if (w_sweep_end) n_state = BS_IDLE;
            BS_INIT:  if (w_sweep_end) n_state = BS_IDLE;
            default:  n_state = BS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_pop       = (r_state == BS_IDLE) && i_valid;
        o_idle      = (r_state == BS_IDLE) && !i_valid;
        o_res_valid = r_res_valid;
        o_res       = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_INIT;
            r_next      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= 1'b0;
            if (r_state == BS_CLEAR && w_sweep_end) begin
                r_next      <= '0;
                r_res_valid <= 1'b1;
            end
            if (w_wr) begin
                r_next <= r_next + CountBits'(1);
            end
            if (r_state == BS_CHECK && (w_free || w_hit || w_last)) begin
                r_res_valid <= 1'b1;
            end
        end
    end

    // Memory write and registered read; a sweep clears one used bit per cycle
    always_ff @(posedge i_clk) begin
        if (w_sweep) begin
            r_used_mem[r_slot] <= 1'b0;
        end else if (w_wr) begin
            r_used_mem[r_slot] <= 1'b1;
        end
        if (w_wr) begin
            r_key_mem[r_slot] <= w_key;
            r_vtx_mem[r_slot] <= r_next[IndexBits-1:0];
        end
        if (r_state == BS_READ) begin
            r_rd_key  <= r_key_mem[r_slot];
            r_rd_vtx  <= r_vtx_mem[r_slot];
            r_rd_used <= r_used_mem[r_slot];
        end
    end

    // Probe pointer and result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (o_pop) begin
            r_job    <= i_job;
            r_slot   <= i_job.clear ? '0 : i_job.slot;
            r_probes <= '0;
        end else if (r_state == BS_CHECK) begin
            r_slot   <= r_slot + SlotBits'(1);
            r_probes <= r_probes + (SlotBits+1)'(1);
        end else if (w_sweep) begin
            r_slot <= r_slot + SlotBits'(1);
        end
        if (r_state == BS_CLEAR && w_sweep_end) begin
            r_res <= '0;
        end else if (r_state == BS_CHECK) begin
            if (w_hit) begin
                r_res <= '{vertex_index: r_rd_vtx, is_new: 1'b0, table_full: 1'b0};
            end else if (w_free && !w_full) begin
                r_res <= '{vertex_index: r_next[IndexBits-1:0], is_new: 1'b1,
                           table_full: 1'b0};
            end else begin
                r_res <= '{vertex_index: '0, is_new: 1'b0, table_full: 1'b1};
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> (r_next == $past(r_next) + CountBits'(1)))
        else $error("insert did not advance vertex count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= CountBits'(TableEntries))
        else $error("vertex count beyond table size");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_CLEAR && w_sweep_end) |=> (r_next == '0 && r_res_valid))
        else $error("clear did not reset count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sweep |-> !o_pop)
        else $error("job taken during sweep");

endmodule

// ----- hw/rtl/vertex_weld_hash_table.sv -----
// Vertex weld hash table: one result per start, on o_res_valid for one cycle.
// A weld result passes the front states, the queue and the back end's read and check
// states, one more read and check per extra probe; a clear sweeps all 4096 used bits.
// The front end takes a new transfer once its job is queued, while the back end works
// on older jobs; when it falls behind, the queue fills and busy holds start off.
// Reset (synchronous, i_rst_n low): quant_shift 20, indices restart, then a sweep of all
// 4096 used bits empties the table; the receiver cannot stall results.
module vertex_weld_hash_table import vwh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [ShiftBits-1:0] i_cfg_data,
    output logic                 o_res_valid,
    output t_out_item            o_res
);

    logic                 w_quant_shift_we;
    logic [ShiftBits-1:0] r_quant_shift;
    logic                 w_front_busy, w_fq_valid, w_fq_ready;
    logic                 w_bq_valid, w_pop, w_back_idle;
    t_job                 w_fq_job, w_bq_job;

    assign busy        = w_front_busy;
    assign o_cfg_ready = 1'b1;
    assign w_quant_shift_we = i_cfg_valid;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant_shift <= QuantShiftReset;
        end else if (w_quant_shift_we) begin
            r_quant_shift <= i_cfg_data;
        end
    end

    vwh_front u_front (
        .i_clk, .i_rst_n,
        .i_take(start && !w_front_busy),
        .i_item,
        .i_quant_shift(r_quant_shift),
        .i_q_ready(w_fq_ready),
        .o_busy(w_front_busy),
        .o_q_valid(w_fq_valid),
        .o_q_job(w_fq_job)
    );

    vwh_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(w_fq_valid), .i_job(w_fq_job), .o_ready(w_fq_ready),
        .i_pop(w_pop), .o_valid(w_bq_valid), .o_job(w_bq_job)
    );

    vwh_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_bq_valid), .i_job(w_bq_job),
        .o_pop(w_pop), .o_idle(w_back_idle),
        .o_res_valid, .o_res
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_res.is_new && o_res.table_full))
        else $error("result both new and full");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_back_idle)
        else $error("back end idle while popping");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for vertex_weld_hash_table: queue-fed driver, strobe monitor,
// and a table model that predicts index, is_new and table_full. Depends on vwh_pkg.
module testbench;
    import vwh_pkg::*;

    localparam int WatchLimit = 50000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in_item             i_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [ShiftBits-1:0] i_cfg_data;
    logic                 o_res_valid;
    t_out_item            o_res;

    vertex_weld_hash_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // Table model
    bit                   slot_busy [TableEntries];
    logic [CoordBits-1:0] slot_kx [TableEntries];
    logic [CoordBits-1:0] slot_ky [TableEntries];
    logic [CoordBits-1:0] slot_kz [TableEntries];
    logic [IndexBits-1:0] slot_idx [TableEntries];
    logic [CountBits-1:0] next_idx;
    logic [ShiftBits-1:0] weld_shift;

    t_in_item  pending_q [$];
    t_out_item weld_q [$];
    t_in_item  seen_pool [$];
    bit        hold;
    int        burst_left;
    int        gap_left;
    int        errors;
    int        idle_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Round |v| half away from zero at the current quantum, then restore the sign.
    function automatic logic [63:0] weld_key(logic [CoordBits-1:0] v, logic [ShiftBits-1:0] s);
        logic                 neg;
        logic [CoordBits-1:0] neg_v;
        logic [63:0]          mag;
        logic [63:0]          k;
        neg   = v[CoordBits-1];
        neg_v = ~v + 1'b1;
        mag   = neg ? {16'b0, neg_v} : {16'b0, v};
        if (neg && mag == 64'd0) mag = 64'd1 << (CoordBits - 1);
        if (s == '0) k = mag;
        else k = (mag + (64'd1 << (s - 1))) >> s;
        return neg ? (~k + 64'd1) : k;
    endfunction

    function automatic t_out_item weld_lookup(t_in_item it);
        t_out_item            r;
        logic [63:0]          kx, ky, kz, h;
        logic [SlotBits-1:0]  slot;
        r = '0;
        if (it.action == ACT_CLEAR) begin
            foreach (slot_busy[i]) slot_busy[i] = 1'b0;
            next_idx = '0;
            return r;
        end
        kx = weld_key(it.coord_x, weld_shift);
        ky = weld_key(it.coord_y, weld_shift);
        kz = weld_key(it.coord_z, weld_shift);
        h  = (kx * 64'd73856093) ^ (ky * 64'd19349663) ^ (kz * 64'd83492791);
        slot = h[SlotBits-1:0];
        for (int n = 0; n < TableEntries; n++) begin
            if (!slot_busy[slot]) begin
                if (next_idx >= TableEntries) break;
                slot_busy[slot] = 1'b1;
                slot_kx[slot]   = kx[CoordBits-1:0];
                slot_ky[slot]   = ky[CoordBits-1:0];
                slot_kz[slot]   = kz[CoordBits-1:0];
                slot_idx[slot]  = next_idx[IndexBits-1:0];
                r.vertex_index  = next_idx[IndexBits-1:0];
                r.is_new        = 1'b1;
                next_idx        = next_idx + 1'b1;
                return r;
            end
            if (slot_kx[slot] == kx[CoordBits-1:0] && slot_ky[slot] == ky[CoordBits-1:0]
                && slot_kz[slot] == kz[CoordBits-1:0]) begin
                r.vertex_index = slot_idx[slot];
                return r;
            end
            slot = slot + 1'b1;
        end
        r.table_full = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Driver: bursts with random gaps, holds an item until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start      <= 1'b0;
            burst_left <= $urandom_range(1, 12);
            gap_left   <= 0;
        end else if (!(start && busy)) begin
            if (start) weld_q.insert(weld_q.size(), weld_lookup(i_item));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (pending_q.size() > 0 && !hold) begin
                start  <= 1'b1;
                i_item <= pending_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: each strobe is one transfer checked against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_res_valid) begin
            if (weld_q.size() == 0) begin
                report_mismatch("unexpected result, index", o_res.vertex_index, 0);
            end else begin
                want = weld_q.pop_front();
                if (o_res.vertex_index !== want.vertex_index)
                    report_mismatch("vertex_index", o_res.vertex_index, want.vertex_index);
                if (o_res.is_new !== want.is_new)
                    report_mismatch("is_new", o_res.is_new, want.is_new);
                if (o_res.table_full !== want.table_full)
                    report_mismatch("table_full", o_res.table_full, want.table_full);
            end
        end
    end

    // Watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchLimit) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_weld(logic [CoordBits-1:0] x, logic [CoordBits-1:0] y,
                             logic [CoordBits-1:0] z);
        t_in_item it;
        it.action  = ACT_WELD;
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        pending_q.insert(pending_q.size(), it);
    endtask

    task automatic push_clear();
        t_in_item it;
        it        = '0;
        it.action = ACT_CLEAR;
        it.coord_x = CoordBits'({$urandom, $urandom});
        pending_q.insert(pending_q.size(), it);
    endtask

    // Send what is pending, then hold the sender until every expected result has come
    task automatic settle();
        while (pending_q.size() > 0 || start) @(posedge i_clk);
        hold <= 1'b1;
        while (weld_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        hold <= 1'b0;
    endtask

    task automatic set_shift(logic [ShiftBits-1:0] s);
        settle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= s;
        do @(posedge i_clk); while (!o_cfg_ready);
        weld_shift = s;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CoordBits-1:0] rand_coord();
        logic signed [CoordBits-1:0] r;
        r = CoordBits'({$urandom, $urandom});
        return r >>> $urandom_range(0, CoordBits - 1);
    endfunction

    initial begin
        logic [ShiftBits-1:0] shifts [8];
        t_in_item it;
        int pick;
        shifts = '{6'd20, 6'd0, 6'd63, 6'd32, 6'd48, 6'd47, 6'd1, 6'd16};
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        hold        = 1'b0;
        errors      = 0;
        idle_cycles = 0;
        weld_shift  = QuantShiftReset;
        next_idx    = '0;
        foreach (slot_busy[i]) slot_busy[i] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, rounding edges at the reset quantum, repeats, clear
        push_weld('0, '0, '0);
        push_weld('0, '0, '0);
        push_weld({1'b0, {47{1'b1}}}, {1'b1, 47'b0}, '1);
        push_weld({1'b1, 47'b0}, {1'b0, {47{1'b1}}}, '1);
        push_weld(48'd524288, -48'sd524288, 48'd524287);
        push_weld(48'd1048575, -48'sd1048575, -48'sd524287);
        push_weld(48'd524288, -48'sd524288, 48'd524287);
        push_weld(48'd1048576, 48'd1, '0);
        push_clear();
        push_weld('0, '0, '0);
        push_weld({1'b0, {47{1'b1}}}, {1'b1, 47'b0}, '1);

        // Long probe chains: x multiples of the table size all hash to slot 0
        set_shift(6'd0);
        push_clear();
        for (int i = 0; i < 48; i++) push_weld(CoordBits'(i) << SlotBits, '0, '0);
        for (int i = 0; i < 12; i++) push_weld(CoordBits'(i * 3) << SlotBits, '0, '0);
        push_weld('0, 48'd7, '0);
        push_clear();
        push_weld(48'd5000, '0, '0);

        // Random phases across quantum settings, extremes included
        foreach (shifts[p]) begin
            set_shift(shifts[p]);
            seen_pool.delete();
            for (int n = 0; n < 100; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    push_clear();
                end else if (pick < 55 && seen_pool.size() > 0) begin
                    it = seen_pool[$urandom_range(0, seen_pool.size() - 1)];
                    push_weld(it.coord_x + $urandom_range(0, 6) - 3,
                              it.coord_y + $urandom_range(0, 6) - 3,
                              it.coord_z + $urandom_range(0, 6) - 3);
                end else begin
                    it.action  = ACT_WELD;
                    it.coord_x = rand_coord();
                    it.coord_y = rand_coord();
                    it.coord_z = rand_coord();
                    if (seen_pool.size() > 64) void'(seen_pool.pop_front());
                    seen_pool.insert(seen_pool.size(), it);
                    push_weld(it.coord_x, it.coord_y, it.coord_z);
                end
            end
        end

        settle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
